>>> rtl/neighbour_queue_table_core_macros.svh
// assertion macros shared by the checker of the neighbour queue table
// depends on nothing; the including file supplies i_clk and i_rst_n
`ifndef NEIGHBOUR_QUEUE_TABLE_CORE_MACROS_SVH
`define NEIGHBOUR_QUEUE_TABLE_CORE_MACROS_SVH

// same-cycle implication, off while reset is low
`define NQT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("neighbour queue table check failed");

// next-cycle implication, off while reset is low
`define NQT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("neighbour queue table check failed");

// next-cycle implication that also holds across reset
`define NQT_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("neighbour queue table check failed");

`endif

>>> rtl/nqt_pkg.sv
// types, codes and helpers of the neighbour queue table
// used by the cell, the top level and the checker
package nqt_pkg;

    localparam int NQT_NEIGHBOURS = 8;
    localparam int NQT_POOL_NODES = 16;
    localparam int NQT_ADDR_BYTES = 8;

    // index field wide enough for the largest entry count the table supports
    localparam int NQT_IDX_MAX_W = 6;

    localparam int NQT_IN_DATA_W  = 72;
    localparam int NQT_IN_USER_W  = 2;
    localparam int NQT_OUT_DATA_W = 16;

    typedef enum logic {
        KIND_ENQUEUE = 1'b0,
        KIND_RELEASE = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_QUEUED    = 3'd0,
        ST_NO_DEST   = 3'd1,
        ST_NO_ENTRY  = 3'd2,
        ST_POOL_FULL = 3'd3,
        ST_RELEASED  = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    // running search result handed from cell to cell
    typedef struct packed {
        logic                     match_hit;
        logic [NQT_IDX_MAX_W-1:0] match_idx;
        logic                     free_hit;
        logic [NQT_IDX_MAX_W-1:0] free_idx;
        logic                     empty_hit;
        logic [NQT_IDX_MAX_W-1:0] empty_idx;
    } t_scan;

    // update applied to the selected cell
    typedef struct packed {
        logic setup;
        logic inc;
        logic dec;
    } t_cell_op;

    function automatic logic [63:0] nqt_byte_mask(input logic [3:0] len);
        logic [63:0] mask;
        mask = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < len) begin
                mask[b*8 +: 8] = 8'hff;
            end
        end
        return mask;
    endfunction

endpackage

>>> rtl/nqt_cell.sv
// one table entry: address, length and queue count, plus one stage of the search chain
// depends on nqt_pkg
module nqt_cell #(
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 3,
    parameter int ADDR_W     = 64,
    parameter int CNT_W      = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nqt_pkg::t_scan       i_scan,
    output nqt_pkg::t_scan       o_scan,
    input  logic [3:0]           i_key_len,
    input  logic [ADDR_W-1:0]    i_key,
    input  nqt_pkg::t_cell_op    i_op,
    input  logic [IDX_W-1:0]     i_op_idx,
    output logic [CNT_W-1:0]     o_count
);
    import nqt_pkg::*;

    localparam logic [NQT_IDX_MAX_W-1:0] MY_IDX = NQT_IDX_MAX_W'(CELL_INDEX);
    localparam logic [IDX_W-1:0]         MY_SEL = IDX_W'(CELL_INDEX);
    // entry 0 belongs to broadcast traffic and never joins the unicast search
    localparam logic                     UNICAST = (CELL_INDEX != 0);

    logic [3:0]        r_len;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_count;
    t_scan             r_scan;

    t_scan             n_scan;
    logic [CNT_W-1:0]  n_count;
    logic              w_sel;

    assign w_sel = (i_op_idx == MY_SEL);

    always_comb begin
        n_scan = i_scan;
        if (UNICAST) begin
            if (!i_scan.match_hit && (r_len == i_key_len) && (r_addr == i_key)) begin
                n_scan.match_hit = 1'b1;
                n_scan.match_idx = MY_IDX;
            end
            if (!i_scan.free_hit && (r_len == 4'd0)) begin
                n_scan.free_hit = 1'b1;
                n_scan.free_idx = MY_IDX;
            end
            if (!i_scan.empty_hit && (r_count == '0)) begin
                n_scan.empty_hit = 1'b1;
                n_scan.empty_idx = MY_IDX;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_sel) begin
            // a fresh entry starts from an empty queue
            if (i_op.setup) begin
                n_count = '0;
            end
            if (i_op.inc) begin
                n_count = n_count + CNT_W'(1);
            end
            if (i_op.dec) begin
                n_count = n_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_count <= '0;
            r_scan  <= '0;
        end else begin
            r_scan  <= n_scan;
            r_count <= n_count;
            if (w_sel && i_op.setup) begin
                r_len <= i_key_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && i_op.setup) begin
            r_addr <= i_key;
        end
    end

    assign o_scan  = r_scan;
    assign o_count = r_count;

endmodule

>>> rtl/neighbour_queue_table_core.sv
// an enqueue of a unicast packet goes from the input transfer through the search state, where
// the registered search chain moves one cell per cycle, to the commit state; broadcast,
// release and items without a valid destination go from the input straight to the commit state.
// one item is in work at a time, so a new item is accepted only once the last has committed;
// a result held by the receiver stalls the next item in its commit cycle.
// synchronous active-low reset frees all entries, empties all queues and the node pool.
module neighbour_queue_table_core #(
    parameter int NEIGHBOURS = nqt_pkg::NQT_NEIGHBOURS,
    parameter int POOL_NODES = nqt_pkg::NQT_POOL_NODES,
    parameter int ADDR_BYTES = nqt_pkg::NQT_ADDR_BYTES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // addr_length[3:0], dest_addr[67:4], release_entry[70:68], zero pad[71]
    input  logic [nqt_pkg::NQT_IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind[0], is_broadcast[1]
    input  logic [nqt_pkg::NQT_IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // status[2:0], entry_index[5:3], new_entry[6], queue_length[11:7], zero pad[15:12]
    output logic [nqt_pkg::NQT_OUT_DATA_W-1:0] o_m_axis_tdata
);
    import nqt_pkg::*;

    localparam int IDX_W  = $clog2(NEIGHBOURS);
    localparam int CNT_W  = $clog2(POOL_NODES + 1);
    localparam int ADDR_W = 8 * ADDR_BYTES;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_scan_cnt;
    logic [CNT_W-1:0]  r_pool_used;
    t_kind             r_kind;
    logic              r_bcast;
    logic [3:0]        r_len;
    logic [ADDR_W-1:0] r_key;
    logic [2:0]        r_rel;
    logic              r_out_valid;
    t_status           r_status;
    logic [2:0]        r_out_idx;
    logic              r_out_new;
    logic [4:0]        r_out_qlen;

    // input field views
    logic              w_in_kind;
    logic              w_in_bcast;
    logic [3:0]        w_in_len;
    logic [63:0]       w_in_addr;
    logic [63:0]       w_in_key;
    logic              w_in_len_bad;
    logic              w_accept;

    t_scan             w_scan [NEIGHBOURS+1];
    logic [CNT_W-1:0]  w_cnt  [NEIGHBOURS];
    t_scan             w_found;

    logic              w_commit;
    logic              w_len_bad;
    logic              w_rel_ok;
    logic              w_hit;
    logic [IDX_W+2:0]  w_rel_wide;
    logic [IDX_W-1:0]  w_sel_idx;
    logic [CNT_W-1:0]  w_cnt_sel;
    logic [CNT_W-1:0]  w_qlen;
    logic [CNT_W+4:0]  w_qlen_wide;
    logic [IDX_W+2:0]  w_idx_wide;
    t_cell_op          w_op;
    t_status           w_status;
    logic              w_fresh;
    logic              w_report_idx;
    logic              w_pool_inc;
    logic              w_pool_dec;

    assign w_in_kind    = i_s_axis_tuser[0];
    assign w_in_bcast   = i_s_axis_tuser[1];
    assign w_in_len     = i_s_axis_tdata[3:0];
    assign w_in_addr    = i_s_axis_tdata[67:4];
    assign w_in_key     = w_in_addr & nqt_byte_mask(w_in_len);
    assign w_in_len_bad = (w_in_len == 4'd0) || (w_in_len > 4'(ADDR_BYTES));

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // search chain: the head sees an empty result, the tail holds the answer
    assign w_scan[0] = '0;
    assign w_found   = w_scan[NEIGHBOURS];

    for (genvar g = 0; g < NEIGHBOURS; g++) begin : g_cell
        nqt_cell #(
            .CELL_INDEX (g),
            .IDX_W      (IDX_W),
            .ADDR_W     (ADDR_W),
            .CNT_W      (CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_scan    (w_scan[g]),
            .o_scan    (w_scan[g+1]),
            .i_key_len (r_len),
            .i_key     (r_key),
            .i_op      (w_op),
            .i_op_idx  (w_sel_idx),
            .o_count   (w_cnt[g])
        );
    end

    assign w_commit   = (r_state == S_COMMIT) && (!r_out_valid || i_m_axis_tready);
    assign w_len_bad  = (r_len == 4'd0) || (r_len > 4'(ADDR_BYTES));
    assign w_rel_ok   = ({29'd0, r_rel} < 32'(NEIGHBOURS));
    assign w_rel_wide = {{IDX_W{1'b0}}, r_rel};
    assign w_hit      = w_found.match_hit || w_found.free_hit || w_found.empty_hit;

    always_comb begin
        if (r_kind == KIND_RELEASE) begin
            w_sel_idx = w_rel_wide[IDX_W-1:0];
        end else if (r_bcast) begin
            w_sel_idx = '0;
        end else if (w_found.match_hit) begin
            w_sel_idx = w_found.match_idx[IDX_W-1:0];
        end else if (w_found.free_hit) begin
            w_sel_idx = w_found.free_idx[IDX_W-1:0];
        end else begin
            w_sel_idx = w_found.empty_idx[IDX_W-1:0];
        end
    end

    assign w_cnt_sel = w_cnt[w_sel_idx];

    always_comb begin
        w_op         = '0;
        w_status     = ST_NO_DEST;
        w_fresh      = 1'b0;
        w_report_idx = 1'b0;
        w_qlen       = '0;
        w_pool_inc   = 1'b0;
        w_pool_dec   = 1'b0;
        if (r_kind == KIND_RELEASE) begin
            w_status = ST_EMPTY;
            if (w_rel_ok) begin
                w_report_idx = 1'b1;
                if (w_cnt_sel != '0) begin
                    w_status   = ST_RELEASED;
                    w_op.dec   = 1'b1;
                    w_qlen     = w_cnt_sel - CNT_W'(1);
                    w_pool_dec = (r_pool_used != '0);
                end
            end
        end else if (!r_bcast && w_len_bad) begin
            w_status = ST_NO_DEST;
        end else if (!r_bcast && !w_hit) begin
            w_status = ST_NO_ENTRY;
        end else begin
            w_report_idx = 1'b1;
            w_fresh      = !r_bcast && !w_found.match_hit;
            w_op.setup   = w_fresh;
            // a new or reclaimed entry always has an empty queue
            w_qlen       = w_fresh ? '0 : w_cnt_sel;
            if (r_pool_used >= CNT_W'(POOL_NODES)) begin
                w_status = ST_POOL_FULL;
            end else begin
                w_status   = ST_QUEUED;
                w_op.inc   = 1'b1;
                w_qlen     = w_qlen + CNT_W'(1);
                w_pool_inc = 1'b1;
            end
        end
        if (!w_commit) begin
            w_op = '0;
        end
    end

    assign w_qlen_wide = {5'd0, w_qlen};
    assign w_idx_wide  = w_report_idx ? {3'd0, w_sel_idx} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_cnt  <= '0;
            r_pool_used <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind     <= t_kind'(w_in_kind);
                        r_bcast    <= w_in_bcast;
                        r_len      <= w_in_len;
                        r_key      <= w_in_key[ADDR_W-1:0];
                        r_rel      <= i_s_axis_tdata[70:68];
                        r_scan_cnt <= '0;
                        if ((t_kind'(w_in_kind) == KIND_ENQUEUE) && !w_in_bcast
                                && !w_in_len_bad) begin
                            r_state <= S_SEARCH;
                        end else begin
                            r_state <= S_COMMIT;
                        end
                    end
                end
                S_SEARCH: begin
                    r_scan_cnt <= r_scan_cnt + IDX_W'(1);
                    if (r_scan_cnt == IDX_W'(NEIGHBOURS - 1)) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_status    <= w_status;
                r_out_idx   <= w_idx_wide[2:0];
                r_out_new   <= w_fresh;
                r_out_qlen  <= w_qlen_wide[4:0];
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_commit && w_pool_inc) begin
                r_pool_used <= r_pool_used + CNT_W'(1);
            end else if (w_commit && w_pool_dec) begin
                r_pool_used <= r_pool_used - CNT_W'(1);
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_qlen, r_out_new, r_out_idx, r_status};

endmodule

>>> rtl/nqt_checker.sv
// port-level checks of the neighbour queue table result channel, bound to the top level
// depends on nqt_pkg and neighbour_queue_table_core_macros.svh
`include "neighbour_queue_table_core_macros.svh"

module nqt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [nqt_pkg::NQT_OUT_DATA_W-1:0] o_m_axis_tdata
);
    import nqt_pkg::*;

    logic [2:0] w_status;
    logic [2:0] w_idx;
    logic       w_new;
    logic [4:0] w_qlen;
    logic       w_reject;
    logic       w_clean;
    logic       w_enq_outcome;

    assign w_status = o_m_axis_tdata[2:0];
    assign w_idx    = o_m_axis_tdata[5:3];
    assign w_new    = o_m_axis_tdata[6];
    assign w_qlen   = o_m_axis_tdata[11:7];

    assign w_reject      = (w_status == ST_NO_DEST) || (w_status == ST_NO_ENTRY);
    assign w_clean       = (w_idx == 3'd0) && !w_new && (w_qlen == 5'd0);
    assign w_enq_outcome = (w_status == ST_QUEUED) || (w_status == ST_POOL_FULL);

    // a stalled result stays offered
    `NQT_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)

    // nothing is offered right after reset
    `NQT_ASSERT_NEXT_ALWAYS(a_reset_quiet, !i_rst_n, !o_m_axis_tvalid)

    // a rejected destination reports no entry index, no new entry and an empty queue
    `NQT_ASSERT_NOW(a_no_dest_clean, o_m_axis_tvalid && w_reject, w_clean)

    // a fresh entry only comes from an enqueue, and a queued packet leaves a nonempty queue
    `NQT_ASSERT_NOW(a_queued_nonzero, o_m_axis_tvalid && w_status == ST_QUEUED, w_qlen != 5'd0)
    `NQT_ASSERT_NOW(a_new_on_enqueue, o_m_axis_tvalid && w_new, w_enq_outcome)

endmodule

bind neighbour_queue_table_core nqt_checker u_nqt_checker (.*);
